// ----- hw/rtl/srw_pkg.sv -----
// Shared types and constants for the selective-repeat receive window.
// No dependencies; every other file in the block except srw_ram imports this package.
package srw_pkg;

  localparam int WINDOW_DEF      = 16;
  localparam int MAX_SEGMENT_DEF = 1024;

  localparam int SEQ_W      = 16;
  localparam int PLEN_W     = 16;
  localparam int DBYTES_W   = 11;
  localparam int CNT_W      = 32;
  localparam int CFG_DATA_W = 32;
  // byte address; bit 2 and up select the register
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_SECOND_TRANSFER = '0;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_FINAL   = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_ACK,
    S_READ,
    S_DELIVER,
    S_FINAL
  } seq_state_t;

  typedef struct packed {
    result_kind_t          result_kind;
    logic [SEQ_W-1:0]      ack_number;
    logic [SEQ_W-1:0]      delivered_seq;
    logic [DBYTES_W-1:0]   delivered_bytes;
    logic [CNT_W-1:0]      byte_offset;
    logic [CNT_W-1:0]      total_bytes;
    logic                  transfer_done;
    logic                  last_of_run;
  } srw_result_t;

endpackage

// ----- hw/rtl/srw_if.sv -----
// Valid/ready channel interfaces: segment headers in, window results out.
// Depends on srw_pkg for field widths.
interface srw_in_if;
  import srw_pkg::*;

  logic              valid;
  logic              ready;
  logic [SEQ_W-1:0]  seq_num;
  logic              is_ack;
  logic              is_syn;
  logic              is_last;
  logic              checksum_ok;
  logic [PLEN_W-1:0] payload_length;

  modport source (
    output valid, seq_num, is_ack, is_syn, is_last, checksum_ok, payload_length,
    input  ready
  );
  modport sink (
    input  valid, seq_num, is_ack, is_syn, is_last, checksum_ok, payload_length,
    output ready
  );
endinterface

interface srw_out_if;
  import srw_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          result_kind;
  logic [SEQ_W-1:0]    ack_number;
  logic [SEQ_W-1:0]    delivered_seq;
  logic [DBYTES_W-1:0] delivered_bytes;
  logic [CNT_W-1:0]    byte_offset;
  logic [CNT_W-1:0]    total_bytes;
  logic                transfer_done;
  logic                last_of_run;

  modport source (
    output valid, result_kind, ack_number, delivered_seq, delivered_bytes,
           byte_offset, total_bytes, transfer_done, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, result_kind, ack_number, delivered_seq, delivered_bytes,
           byte_offset, total_bytes, transfer_done, last_of_run,
    output ready
  );
endinterface

// ----- hw/rtl/srw_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module srw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/srw_cfg.sv -----
// APB-style register port holding the second_transfer mode bit.
// Depends on srw_pkg.
module srw_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srw_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [srw_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [srw_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic                            second_transfer
);
  import srw_pkg::*;

  logic                 second_r;
  logic                 second_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_hit;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_hit  = psel && penable && pwrite && (reg_idx == REG_SECOND_TRANSFER);

  always_comb begin
    second_nxt = second_r;
    if (wr_hit) begin
      second_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
    end else begin
      second_r <= second_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_SECOND_TRANSFER) begin
      prdata = {{(CFG_DATA_W-1){1'b0}}, second_r};
    end
  end

  assign pready          = 1'b1;
  assign second_transfer = second_r;

endmodule

// ----- hw/rtl/srw_seq.sv -----
// Window sequencer: classifies a header, buffers the slot, then walks the
// in-order slots one delivery at a time. Depends on srw_pkg, srw_if, srw_ram.
module srw_seq #(
  parameter int WINDOW      = srw_pkg::WINDOW_DEF,
  parameter int MAX_SEGMENT = srw_pkg::MAX_SEGMENT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  srw_in_if.sink               in_ch,
  input  logic                 second_transfer,
  input  logic                 out_free,
  output logic                 res_push,
  output srw_pkg::srw_result_t res
);
  import srw_pkg::*;

  localparam int IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SLOT_LEN_W = $clog2(MAX_SEGMENT + 1);
  localparam int WORD_W     = SLOT_LEN_W + 1;

  localparam logic [IDX_W:0]     WIN_EXT  = (IDX_W+1)'(WINDOW);
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(WINDOW - 1);
  localparam logic [SEQ_W-1:0]   WIN_SEQ  = SEQ_W'(WINDOW);
  localparam logic [PLEN_W-1:0]  SEG_CAP  = PLEN_W'(MAX_SEGMENT);
  localparam logic [CNT_W-1:0]   SEG_STEP = CNT_W'(MAX_SEGMENT);

  seq_state_t state_r, state_nxt;

  // latched header
  logic [SEQ_W-1:0]  seq_r;
  logic              ack_r, syn_r, last_r, ok_r;
  logic [PLEN_W-1:0] plen_r;

  // window state
  logic [SEQ_W-1:0]  base_r, base_nxt;
  logic [IDX_W-1:0]  base_idx_r, base_idx_nxt;
  logic [WINDOW-1:0] recv_r, recv_nxt;
  logic [CNT_W-1:0]  offset_r, offset_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic              finished_r, finished_nxt;
  logic              start_r, start_nxt;

  // classification
  logic [SEQ_W-1:0]  ahead, behind;
  logic              in_win, in_prev, filtered, take, repeat_ack;
  logic [IDX_W:0]    slot_sum, slot_wrap;
  logic [IDX_W-1:0]  wr_idx;
  logic [PLEN_W-1:0] cap_len;

  // delivery
  logic [WORD_W-1:0]     ram_rdata;
  logic [SLOT_LEN_W-1:0] rd_len;
  logic                  rd_last;
  logic [CNT_W:0]        sum_ext;
  logic [CNT_W-1:0]      total_sat;
  logic [IDX_W-1:0]      next_idx;
  logic                  next_recv;
  logic                  ram_we;

  assign ahead      = seq_r - base_r;
  assign behind     = base_r - seq_r;
  assign in_win     = ahead < WIN_SEQ;
  assign in_prev    = (behind != '0) && (behind <= WIN_SEQ);
  assign filtered   = (second_transfer && (base_r == '0) && last_r) || ack_r || syn_r;
  assign take       = ok_r && !finished_r && in_win && !filtered;
  assign repeat_ack = ok_r && !finished_r && !in_win && in_prev;

  // physical slot = (base_idx + ahead) mod WINDOW, both terms below WINDOW
  assign slot_sum  = {1'b0, base_idx_r} + {1'b0, ahead[IDX_W-1:0]};
  assign slot_wrap = slot_sum - WIN_EXT;
  assign wr_idx    = (slot_sum >= WIN_EXT) ? slot_wrap[IDX_W-1:0] : slot_sum[IDX_W-1:0];
  assign cap_len   = (plen_r < SEG_CAP) ? plen_r : SEG_CAP;

  assign rd_len    = ram_rdata[SLOT_LEN_W-1:0];
  assign rd_last   = ram_rdata[SLOT_LEN_W];
  assign sum_ext   = {1'b0, total_r} + (CNT_W+1)'(rd_len);
  assign total_sat = sum_ext[CNT_W] ? '1 : sum_ext[CNT_W-1:0];
  assign next_idx  = (base_idx_r == LAST_IDX) ? '0 : base_idx_r + 1'b1;
  // with a one-slot window the next slot is the one being freed
  assign next_recv = recv_r[next_idx] && (next_idx != base_idx_r);

  assign ram_we = (state_r == S_EVAL) && take;

  srw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WINDOW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata ({last_r, cap_len[SLOT_LEN_W-1:0]}),
    .raddr (base_idx_r),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = (take || repeat_ack) ? S_ACK : S_IDLE;
      end
      S_ACK: begin
        if (out_free) state_nxt = start_r ? S_READ : S_IDLE;
      end
      S_READ: begin
        state_nxt = S_DELIVER;
      end
      S_DELIVER: begin
        if (out_free) begin
          if (rd_last) begin
            state_nxt = second_transfer ? S_FINAL : S_IDLE;
          end else begin
            state_nxt = next_recv ? S_READ : S_IDLE;
          end
        end
      end
      S_FINAL: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = 1'b0;
    res_push    = 1'b0;
    res         = '0;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
      end
      S_ACK: begin
        res_push        = out_free;
        res.result_kind = KIND_ACK;
        res.ack_number  = seq_r;
        res.last_of_run = !start_r;
      end
      S_DELIVER: begin
        res_push            = out_free;
        res.result_kind     = KIND_DELIVER;
        res.delivered_seq   = base_r;
        res.delivered_bytes = DBYTES_W'(rd_len);
        res.byte_offset     = offset_r;
        res.total_bytes     = total_sat;
        res.transfer_done   = rd_last;
        res.last_of_run     = rd_last ? !second_transfer : !next_recv;
      end
      S_FINAL: begin
        res_push          = out_free;
        res.result_kind   = KIND_FINAL;
        res.ack_number    = seq_r;
        res.total_bytes   = total_r;
        res.transfer_done = 1'b1;
        res.last_of_run   = 1'b1;
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  // window datapath
  always_comb begin
    base_nxt     = base_r;
    base_idx_nxt = base_idx_r;
    recv_nxt     = recv_r;
    offset_nxt   = offset_r;
    total_nxt    = total_r;
    finished_nxt = finished_r;
    start_nxt    = start_r;
    case (state_r)
      S_EVAL: begin
        start_nxt = take && (ahead == '0);
        if (take) recv_nxt[wr_idx] = 1'b1;
      end
      S_DELIVER: begin
        if (out_free) begin
          total_nxt = total_sat;
          if (rd_last) begin
            finished_nxt = 1'b1;
          end else begin
            base_nxt             = base_r + 1'b1;
            base_idx_nxt         = next_idx;
            recv_nxt[base_idx_r] = 1'b0;
            offset_nxt           = offset_r + SEG_STEP;
          end
        end
      end
      default: begin
        start_nxt = start_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      base_r     <= '0;
      base_idx_r <= '0;
      recv_r     <= '0;
      offset_r   <= '0;
      total_r    <= '0;
      finished_r <= 1'b0;
      start_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      base_r     <= base_nxt;
      base_idx_r <= base_idx_nxt;
      recv_r     <= recv_nxt;
      offset_r   <= offset_nxt;
      total_r    <= total_nxt;
      finished_r <= finished_nxt;
      start_r    <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      seq_r  <= in_ch.seq_num;
      ack_r  <= in_ch.is_ack;
      syn_r  <= in_ch.is_syn;
      last_r <= in_ch.is_last;
      ok_r   <= in_ch.checksum_ok;
      plen_r <= in_ch.payload_length;
    end
  end

endmodule

// ----- hw/rtl/selective_repeat_receive_window_core.sv -----
// Channel    Dir  Handshake          Carries
// in_ch      in   valid/ready        one segment header per item
// out_ch     out  valid/ready        ACK, in-order delivery or final ACK|LAST
// apb        in   psel/penable/pwr.  second_transfer mode bit at byte 0
//
// An item that yields nothing passes accept and classify; one that yields an ACK
// passes accept, classify and ACK, followed by a slot RAM read and an emit for each
// in-order delivery and, with second_transfer set, a final ACK|LAST; the registered
// read of the slot RAM is why each delivery needs its own read step.
// Reset (rst_n low, synchronous) clears window base, received marks, counters
// and the done flag at once. A full output register holds the sequencer until
// the item is taken; in_ch.ready is high only while no header is in work.
// Top level: config port, window sequencer and output register.
// Depends on srw_pkg, srw_if, srw_cfg, srw_seq.
module selective_repeat_receive_window_core #(
  parameter int WINDOW      = srw_pkg::WINDOW_DEF,
  parameter int MAX_SEGMENT = srw_pkg::MAX_SEGMENT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  srw_in_if.sink                         in_ch,
  srw_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [srw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [srw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [srw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import srw_pkg::*;

  logic        second_transfer;
  logic        out_free;
  logic        res_push;
  srw_result_t res;

  logic        out_vld_r, out_vld_nxt;
  srw_result_t out_res_r;

  srw_cfg u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .second_transfer (second_transfer)
  );

  srw_seq #(
    .WINDOW      (WINDOW),
    .MAX_SEGMENT (MAX_SEGMENT)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .second_transfer (second_transfer),
    .out_free        (out_free),
    .res_push        (res_push),
    .res             (res)
  );

  assign out_free = !out_vld_r || out_ch.ready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res_push) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.result_kind     = out_res_r.result_kind;
  assign out_ch.ack_number      = out_res_r.ack_number;
  assign out_ch.delivered_seq   = out_res_r.delivered_seq;
  assign out_ch.delivered_bytes = out_res_r.delivered_bytes;
  assign out_ch.byte_offset     = out_res_r.byte_offset;
  assign out_ch.total_bytes     = out_res_r.total_bytes;
  assign out_ch.transfer_done   = out_res_r.transfer_done;
  assign out_ch.last_of_run     = out_res_r.last_of_run;

endmodule
